/* hdl/pspc_pkg.sv */
// Shared types and constants for the projector serial poll controller.
// Used by pspc_answer_buf, pspc_ctrl and projector_serial_poll_controller.
`timescale 1ns / 1ps

package pspc_pkg;

    // Reply buffer geometry
    localparam int ANSWER_DEPTH = 10;
    localparam int ANS_LEN_W    = $clog2(ANSWER_DEPTH + 1);
    localparam int ANS_IDX_W    = $clog2(ANSWER_DEPTH);
    localparam int PWR_REPLY_LEN = 6;

    // Field widths
    localparam int TICK_W = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CMD_W = 3;
    localparam int PSTATE_W = 3;

    // Request actions
    typedef enum logic [1:0] {
        ACT_TICK    = 2'd0,
        ACT_PWR_ON  = 2'd1,
        ACT_PWR_OFF = 2'd2,
        ACT_POLL    = 2'd3
    } action_t;

    // Pending command queue slot
    typedef enum logic [2:0] {
        PEND_PWRQ = 3'd0,
        PEND_ERRQ = 3'd1,
        PEND_SRCQ = 3'd2,
        PEND_OFF  = 3'd3,
        PEND_ON   = 3'd4
    } pend_t;

    // Command codes on the result channel
    localparam logic [CMD_W-1:0] CMD_NONE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PWRQ = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ERRQ = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SRCQ = 3'd3;
    localparam logic [CMD_W-1:0] CMD_OFF  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_ON   = 3'd5;

    // Projector power states
    localparam logic [PSTATE_W-1:0] PST_OFF     = 3'd0;
    localparam logic [PSTATE_W-1:0] PST_ON      = 3'd1;
    localparam logic [PSTATE_W-1:0] PST_UNKNOWN = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROMPT = 2'd2;

    // Configuration reset values
    localparam logic [TICK_W-1:0] GAP_RST    = 7'd5;
    localparam logic [TICK_W-1:0] REPLY_RST  = 7'd60;
    localparam logic [TICK_W-1:0] PROMPT_RST = 7'd120;
    localparam logic [TICK_W-1:0] WDOG_RST   = 7'd5;

    // Characters of interest
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_P     = 8'h50;
    localparam logic [7:0] CHAR_W     = 8'h57;
    localparam logic [7:0] CHAR_R     = 8'h52;
    localparam logic [7:0] CHAR_EQ    = 8'h3D;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_3     = 8'h33;

    // Byte event from the reply buffer to the controller
    typedef struct packed {
        logic       colon;
        logic       pwr_hit;
        logic [1:0] pwr_code;
    } rx_evt_t;

endpackage

/* hdl/pspc_answer_buf.sv */
// Reply line buffer: collects received bytes and decodes PWR=0n on carriage return.
// Depends on pspc_pkg.
`timescale 1ns / 1ps

module pspc_answer_buf (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            byte_en,
    input  logic [7:0]      rx_byte,
    output pspc_pkg::rx_evt_t evt
);
    import pspc_pkg::*;

    logic [7:0]           ans_reg [ANSWER_DEPTH];
    logic [ANS_LEN_W-1:0] len_reg;
    logic [ANS_LEN_W-1:0] len_next;
    logic                 is_cr;
    logic                 is_colon;
    logic                 room;
    logic                 append;
    logic                 line_ok;

    // Classify the byte
    assign is_cr    = (rx_byte == CHAR_CR);
    assign is_colon = (rx_byte == CHAR_COLON);
    assign room     = (len_reg < ANS_LEN_W'(ANSWER_DEPTH));
    assign append   = byte_en && !is_cr && !is_colon && room;

    // Match an exact six-character power reply
    assign line_ok = (len_reg == ANS_LEN_W'(PWR_REPLY_LEN)) &&
                     (ans_reg[0] == CHAR_P) && (ans_reg[1] == CHAR_W) &&
                     (ans_reg[2] == CHAR_R) && (ans_reg[3] == CHAR_EQ) &&
                     (ans_reg[4] == CHAR_0) &&
                     (ans_reg[5] >= CHAR_0) && (ans_reg[5] <= CHAR_3);

    always_comb begin
        evt.colon    = byte_en && is_colon;
        evt.pwr_hit  = byte_en && is_cr && line_ok;
        evt.pwr_code = ans_reg[5][1:0];
    end

    // Clear on carriage return, advance on append
    always_comb begin
        len_next = len_reg;
        if (byte_en && is_cr) begin
            len_next = '0;
        end else if (append) begin
            len_next = len_reg + ANS_LEN_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
        end else begin
            len_reg <= len_next;
        end
    end

    // Store the byte at the fill position
    always_ff @(posedge aclk) begin
        if (append) begin
            ans_reg[len_reg[ANS_IDX_W-1:0]] <= rx_byte;
        end
    end

endmodule

/* hdl/pspc_ctrl.sv */
// Controller core: config registers, gap timer, watchdog, command sequencing.
// Depends on pspc_pkg; takes byte events from pspc_answer_buf.
`timescale 1ns / 1ps

module pspc_ctrl (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [pspc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pspc_pkg::TICK_W-1:0]        cfg_wdata,
    input  logic                               advance,
    input  pspc_pkg::action_t                  action,
    input  pspc_pkg::rx_evt_t                  evt,
    output logic                               send_newline,
    output logic [pspc_pkg::CMD_W-1:0]         command_out,
    output logic [pspc_pkg::PSTATE_W-1:0]      projector_state
);
    import pspc_pkg::*;

    logic [TICK_W-1:0]   gap_cfg_reg;
    logic [TICK_W-1:0]   reply_cfg_reg;
    logic [TICK_W-1:0]   prompt_cfg_reg;
    logic [TICK_W-1:0]   gap_reg, gap_next;
    logic [TICK_W-1:0]   wdog_reg, wdog_next;
    logic                ready_reg, ready_next;
    pend_t               pend_reg, pend_next;
    logic [PSTATE_W-1:0] power_reg, power_next;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_cfg_reg    <= GAP_RST;
            reply_cfg_reg  <= REPLY_RST;
            prompt_cfg_reg <= PROMPT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_GAP:    gap_cfg_reg    <= cfg_wdata;
                CFG_REPLY:  reply_cfg_reg  <= cfg_wdata;
                CFG_PROMPT: prompt_cfg_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Process one request
    always_comb begin
        gap_next     = gap_reg;
        wdog_next    = wdog_reg;
        ready_next   = ready_reg;
        pend_next    = pend_reg;
        power_next   = power_reg;
        send_newline = 1'b0;
        command_out  = CMD_NONE;
        if (advance) begin
            unique case (action)
                ACT_TICK: begin
                    if (gap_reg != '0) gap_next = gap_reg - TICK_W'(1);
                    if (wdog_reg != '0) wdog_next = wdog_reg - TICK_W'(1);
                end
                ACT_PWR_ON: begin
                    pend_next = PEND_ON;
                end
                ACT_PWR_OFF: begin
                    pend_next = PEND_OFF;
                end
                ACT_POLL: begin
                    // Watchdog expired: kick the line
                    if (wdog_reg == '0) begin
                        send_newline = 1'b1;
                        wdog_next    = TICK_W'(1);
                    end
                    // Send the pending command once the projector is ready and the gap has run out
                    if (ready_reg && (gap_reg == '0)) begin
                        case (pend_reg)
                            PEND_ERRQ: begin
                                command_out = CMD_ERRQ;
                                pend_next = (power_reg == PST_ON) ? PEND_SRCQ : PEND_PWRQ;
                            end
                            PEND_SRCQ: begin
                                command_out = CMD_SRCQ;
                                pend_next   = PEND_PWRQ;
                            end
                            PEND_OFF: begin
                                command_out = CMD_OFF;
                                pend_next   = PEND_PWRQ;
                            end
                            PEND_ON: begin
                                command_out = CMD_ON;
                                pend_next   = PEND_PWRQ;
                            end
                            default: begin
                                command_out = CMD_PWRQ;
                                pend_next = (power_reg == PST_ON) ? PEND_ERRQ : PEND_PWRQ;
                            end
                        endcase
                        ready_next = 1'b0;
                        wdog_next  = reply_cfg_reg;
                        gap_next   = gap_cfg_reg;
                    end
                    // Prompt seen: projector is ready again
                    if (evt.colon) begin
                        ready_next = 1'b1;
                        wdog_next  = prompt_cfg_reg;
                    end
                    if (evt.pwr_hit) begin
                        power_next = {1'b0, evt.pwr_code};
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign projector_state = power_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_reg   <= '0;
            wdog_reg  <= WDOG_RST;
            ready_reg <= 1'b1;
            pend_reg  <= PEND_PWRQ;
            power_reg <= PST_UNKNOWN;
        end else begin
            gap_reg   <= gap_next;
            wdog_reg  <= wdog_next;
            ready_reg <= ready_next;
            pend_reg  <= pend_next;
            power_reg <= power_next;
        end
    end

endmodule

/* hdl/projector_serial_poll_controller.sv */
// Top level of the projector serial poll controller: input and result registers.
// Depends on pspc_pkg, pspc_answer_buf and pspc_ctrl.
//
// Channel  Dir  Handshake          Payload
// s_       in   s_valid/s_ready    s_action[1:0], s_byte_valid, s_rx_byte[7:0]
// m_       out  m_valid/m_ready    m_send_newline, m_command_out[2:0],
//                                  m_projector_state[2:0]
// cfg_     in   cfg_wr_en          cfg_index[1:0], cfg_wdata[6:0]
//
// One request per cycle sustained while the result channel is not stalled; each request passes
// the request register and then the result register before its result is presented.
// The request register feeds one pass of compare and counter logic into the result
// register; state updates on the same edge that loads the result.
// Reset (aresetn low, synchronous) empties both stages and loads register defaults.
// A stalled result holds the request register; s_ready stays high while either
// stage can still move.
`timescale 1ns / 1ps

module projector_serial_poll_controller (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_action,
    input  logic                           s_byte_valid,
    input  logic [7:0]                     s_rx_byte,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_send_newline,
    output logic [pspc_pkg::CMD_W-1:0]     m_command_out,
    output logic [pspc_pkg::PSTATE_W-1:0]  m_projector_state,
    input  logic                           cfg_wr_en,
    input  logic [pspc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pspc_pkg::TICK_W-1:0]    cfg_wdata
);
    import pspc_pkg::*;

    logic                in_valid_reg;
    logic [1:0]          action_reg;
    logic                byte_valid_reg;
    logic [7:0]          rx_byte_reg;
    logic                out_valid_reg;
    logic                nl_reg;
    logic [CMD_W-1:0]    cmd_reg;
    logic [PSTATE_W-1:0] pstate_reg;
    logic                advance;
    logic                byte_en;
    action_t             action;
    rx_evt_t             evt;
    logic                nl_next;
    logic [CMD_W-1:0]    cmd_next;
    logic [PSTATE_W-1:0] pstate_next;

    // Pipeline control
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign action  = action_t'(action_reg);
    assign byte_en = advance && (action == ACT_POLL) && byte_valid_reg;

    // Request register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            action_reg     <= s_action;
            byte_valid_reg <= s_byte_valid;
            rx_byte_reg    <= s_rx_byte;
        end
    end

    pspc_answer_buf u_answer_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .byte_en (byte_en),
        .rx_byte (rx_byte_reg),
        .evt     (evt)
    );

    pspc_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .advance         (advance),
        .action          (action),
        .evt             (evt),
        .send_newline    (nl_next),
        .command_out     (cmd_next),
        .projector_state (pstate_next)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            nl_reg     <= nl_next;
            cmd_reg    <= cmd_next;
            pstate_reg <= pstate_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_send_newline    = nl_reg;
    assign m_command_out     = cmd_reg;
    assign m_projector_state = pstate_reg;

endmodule
